// File: hw/rtl/bmhq_pkg.sv
// bmhq_pkg: shared sizes, codes and types of the binary max-heap priority queue
// used by the channel interfaces and the top level
`default_nettype none

package bmhq_pkg;

   // queue sizing
   localparam int CAPACITY = 128;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CHILD_W  = CNT_W + 1;

   // fixed field widths
   localparam int DATA_W   = 32;
   localparam int FILL_W   = 8;

   // request action codes
   typedef enum logic {
      ACT_INSERT = 1'b0,
      ACT_REMOVE = 1'b1
   } action_type;

   // response status codes
   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_REMOVED  = 2'd1,
      ST_FULL     = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

endpackage

`default_nettype wire

// File: hw/rtl/bmhq_req_if.sv
// bmhq_req_if: request channel of the heap queue (valid/ready plus action and value)
// depends on bmhq_pkg
`default_nettype none

interface bmhq_req_if
   import bmhq_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic                     action;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/bmhq_rsp_if.sv
// bmhq_rsp_if: response channel of the heap queue (valid/ready plus result fields)
// depends on bmhq_pkg
`default_nettype none

interface bmhq_rsp_if
   import bmhq_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] out_value;
   logic [1:0]               status;
   logic [FILL_W-1:0]        fill_count;

   modport source (output valid, output out_value, output status, output fill_count,
                   input ready);
   modport sink   (input valid, input out_value, input status, input fill_count,
                   output ready);
endinterface

`default_nettype wire

// File: hw/rtl/bmhq_ram.sv
// bmhq_ram: generic simple dual-port ram, one write and one registered read per cycle
// no dependencies; a read of the address being written returns the old data
`default_nettype none

module bmhq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage array and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/binary_max_heap_queue.sv
// binary_max_heap_queue: max-priority queue kept as an implicit binary heap in one ram
// depends on bmhq_pkg, bmhq_req_if, bmhq_rsp_if and bmhq_ram
//
// Usage:
//   req_chan carries one request: action insert (with a signed 32-bit value) or
//   remove. Each request gives exactly one response on rsp_chan: the removed
//   maximum (zero otherwise), a status (inserted, removed, full, empty) and the
//   entry count after the request. Both channels move a request on valid & ready.
//   One request is worked on at a time; req_chan.ready is high while the block is
//   idle, also while the previous response still waits in the output register.
//   The work is paced by the single read port of the heap ram (one registered read per
//   cycle): an insert reads one parent per level while it climbs (an insert into an
//   empty queue writes the root directly); a removal reads the root and the last
//   entry, then spends up to two reads per level it sinks. Full and empty requests
//   touch no ram. The response is visible the cycle after the work ends, provided
//   the output register is free.
//   If rsp_chan stalls, the finished response is held and the block waits before
//   loading the next one. Reset empties the queue (count zero) and drops any
//   pending response; the ram is not cleared, entries are only read once written.
`default_nettype none

module binary_max_heap_queue
   import bmhq_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   bmhq_req_if.sink    req_chan,
   bmhq_rsp_if.source  rsp_chan
);

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_UP      = 8'b0000_0010,
      S_HOLE    = 8'b0000_0100,
      S_RM_TOP  = 8'b0000_1000,
      S_RM_LAST = 8'b0001_0000,
      S_DN_L    = 8'b0010_0000,
      S_DN_R    = 8'b0100_0000,
      S_DONE    = 8'b1000_0000
   } state_type;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [ADDR_W-1:0]        pos_ff, pos_in;
   logic [ADDR_W-1:0]        par_ff, par_in;
   logic signed [DATA_W-1:0] hold_ff, hold_in;
   logic signed [DATA_W-1:0] left_ff, left_in;
   logic signed [DATA_W-1:0] res_val_ff, res_val_in;
   status_type               res_st_ff, res_st_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [FILL_W-1:0]        rsp_fill_ff, rsp_fill_in;

   logic                     ram_wr_en;
   logic [ADDR_W-1:0]        ram_wr_addr;
   logic [DATA_W-1:0]        ram_wr_data;
   logic                     ram_rd_en;
   logic [ADDR_W-1:0]        ram_rd_addr;
   logic [DATA_W-1:0]        ram_rd_data;
   logic signed [DATA_W-1:0] rd_val;

   logic [CHILD_W-1:0]       count_ext;
   logic [CHILD_W-1:0]       lchild;
   logic [CHILD_W-1:0]       rchild;
   logic [ADDR_W-1:0]        up_par;
   logic signed [DATA_W-1:0] dn_left;
   logic signed [DATA_W-1:0] dn_cand;
   logic                     go_left;
   logic                     go_right;
   logic [ADDR_W-1:0]        dn_pos;
   logic [CHILD_W-1:0]       dn_lchild;

   // heap storage
   bmhq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_heap_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_val = $signed(ram_rd_data);

   // child and parent indexes of the current position
   assign count_ext = CHILD_W'(count_ff);
   assign lchild    = (CHILD_W'(pos_ff) << 1) + CHILD_W'(1);
   assign rchild    = lchild + CHILD_W'(1);
   assign up_par    = (par_ff - ADDR_W'(1)) >> 1;

   // sift-down choice: left first, right only if strictly larger than the winner
   assign dn_left   = (state_ff == S_DN_R) ? left_ff : rd_val;
   assign go_left   = dn_left > hold_ff;
   assign dn_cand   = go_left ? dn_left : hold_ff;
   assign go_right  = (state_ff == S_DN_R) && (rd_val > dn_cand);
   assign dn_pos    = go_right ? rchild[ADDR_W-1:0] : lchild[ADDR_W-1:0];
   assign dn_lchild = (CHILD_W'(dn_pos) << 1) + CHILD_W'(1);

   // sequencer and ram access
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      par_in        = par_ff;
      hold_in       = hold_ff;
      left_in       = left_ff;
      res_val_in    = res_val_ff;
      res_st_in     = res_st_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_fill_in   = rsp_fill_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = pos_ff;
      ram_wr_data   = hold_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.action == ACT_INSERT) begin
                  res_val_in = '0;
                  if (count_ff == CNT_W'(CAPACITY)) begin
                     res_st_in = ST_FULL;
                     state_in  = S_DONE;
                  end else begin
                     res_st_in = ST_INSERTED;
                     hold_in   = req_chan.value;
                     pos_in    = count_ff[ADDR_W-1:0];
                     count_in  = count_ff + CNT_W'(1);
                     if (count_ff == '0) begin
                        // first entry goes straight to the root
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = '0;
                        ram_wr_data = req_chan.value;
                        state_in    = S_DONE;
                     end else begin
                        par_in      = (count_ff[ADDR_W-1:0] - ADDR_W'(1)) >> 1;
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = (count_ff[ADDR_W-1:0] - ADDR_W'(1)) >> 1;
                        state_in    = S_UP;
                     end
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_val_in = '0;
                     res_st_in  = ST_EMPTY;
                     state_in   = S_DONE;
                  end else begin
                     res_st_in   = ST_REMOVED;
                     count_in    = count_ff - CNT_W'(1);
                     pos_in      = '0;
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = '0;
                     state_in    = S_RM_TOP;
                  end
               end
            end
         end

         S_UP: begin
            // parent data has arrived: move it down or settle the new value
            ram_wr_en = 1'b1;
            if (hold_ff > rd_val) begin
               ram_wr_data = ram_rd_data;
               pos_in      = par_ff;
               if (par_ff == '0) begin
                  state_in = S_HOLE;
               end else begin
                  par_in      = up_par;
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = up_par;
               end
            end else begin
               state_in = S_DONE;
            end
         end

         S_HOLE: begin
            ram_wr_en = 1'b1;
            state_in  = S_DONE;
         end

         S_RM_TOP: begin
            // root is the result; fetch the last entry unless the queue is now empty
            res_val_in = rd_val;
            if (count_ff == '0) begin
               state_in = S_DONE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = count_ff[ADDR_W-1:0];
               state_in    = S_RM_LAST;
            end
         end

         S_RM_LAST: begin
            // last entry becomes the sinking value at the root
            hold_in = rd_val;
            if (lchild >= count_ext) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = '0;
               ram_wr_data = ram_rd_data;
               state_in    = S_DONE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = lchild[ADDR_W-1:0];
               state_in    = S_DN_L;
            end
         end

         S_DN_L, S_DN_R: begin
            left_in = dn_left;
            if ((state_ff == S_DN_L) && (rchild < count_ext)) begin
               // fetch the right child before deciding
               ram_rd_en   = 1'b1;
               ram_rd_addr = rchild[ADDR_W-1:0];
               state_in    = S_DN_R;
            end else begin
               ram_wr_en = 1'b1;
               if (go_right || go_left) begin
                  ram_wr_data = go_right ? ram_rd_data : dn_left;
                  pos_in      = dn_pos;
                  if (dn_lchild >= count_ext) begin
                     state_in = S_HOLE;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = dn_lchild[ADDR_W-1:0];
                     state_in    = S_DN_L;
                  end
               end else begin
                  state_in = S_DONE;
               end
            end
         end

         S_DONE: begin
            // load the output register once it is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_val_ff;
               rsp_status_in = res_st_ff;
               rsp_fill_in   = FILL_W'(count_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      par_ff        <= par_in;
      hold_ff       <= hold_in;
      left_ff       <= left_in;
      res_val_ff    <= res_val_in;
      res_st_ff     <= res_st_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fill_ff   <= rsp_fill_in;
   end

   // channel outputs
   assign req_chan.ready      = (state_ff == S_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_value  = rsp_value_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.fill_count = rsp_fill_ff;

endmodule

`default_nettype wire

// File: bench/tb_binary_max_heap_queue.sv
// tb_binary_max_heap_queue: self-checking bench for the binary max-heap priority queue
// depends on bmhq_pkg, bmhq_req_if, bmhq_rsp_if and binary_max_heap_queue
// a table of directed requests, then random fill/drain/mixed phases, checked against a heap
`default_nettype none

module tb_binary_max_heap_queue;
   import bmhq_pkg::*;

   // one response as the queue reports it
   typedef struct packed {
      logic signed [DATA_W-1:0] out_value;
      status_type               status;
      logic [FILL_W-1:0]        fill_count;
   } reply_type;

   // one row of the directed table; want is used only when typed is set
   typedef struct {
      action_type               act;
      logic signed [DATA_W-1:0] val;
      bit                       typed;
      reply_type                want;
   } dir_row_type;

   localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam int RANDOM_ITEMS = 1850;
   localparam int SHOW_LIMIT   = 40;

   logic clock;
   logic reset;

   bmhq_req_if req_bus ();
   bmhq_rsp_if rsp_bus ();

   binary_max_heap_queue u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // shadow heap and the responses still owed by the queue
   logic signed [DATA_W-1:0] shadow_heap [CAPACITY];
   int                       shadow_len;
   reply_type                replies_due [$];
   dir_row_type              dir_rows [$];
   int                       error_count;
   int                       items_sent;
   int                       burst_left;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hard stop in case the queue hangs
   initial begin
      #(12 * 700_000);
      $display("CHECK FAILED");
      $finish;
   end

   // apply one request to the shadow heap and return the response it should give
   function automatic reply_type heap_step(input action_type act,
                                           input logic signed [DATA_W-1:0] val);
      reply_type                r;
      int                       pos, up, lc, rc, best;
      bit                       done;
      logic signed [DATA_W-1:0] tmp;
      r.out_value = '0;
      if (act == ACT_INSERT) begin
         if (shadow_len >= CAPACITY) begin
            r.status = ST_FULL;
         end else begin
            // append, then climb while strictly above the parent
            pos = shadow_len;
            shadow_heap[pos] = val;
            shadow_len++;
            done = 1'b0;
            while (pos > 0 && !done) begin
               up = (pos - 1) / 2;
               if (shadow_heap[pos] > shadow_heap[up]) begin
                  tmp = shadow_heap[pos];
                  shadow_heap[pos] = shadow_heap[up];
                  shadow_heap[up] = tmp;
                  pos = up;
               end else begin
                  done = 1'b1;
               end
            end
            r.status = ST_INSERTED;
         end
      end else begin
         if (shadow_len == 0) begin
            r.status = ST_EMPTY;
         end else begin
            // take the root, move the last entry up and sink it
            r.out_value = shadow_heap[0];
            shadow_len--;
            shadow_heap[0] = shadow_heap[shadow_len];
            pos = 0;
            done = 1'b0;
            while (!done) begin
               lc = 2 * pos + 1;
               rc = lc + 1;
               best = pos;
               // left child wins a tie because the right one must be strictly larger
               if (lc < shadow_len && shadow_heap[lc] > shadow_heap[best]) best = lc;
               if (rc < shadow_len && shadow_heap[rc] > shadow_heap[best]) best = rc;
               if (best == pos) begin
                  done = 1'b1;
               end else begin
                  tmp = shadow_heap[pos];
                  shadow_heap[pos] = shadow_heap[best];
                  shadow_heap[best] = tmp;
                  pos = best;
               end
            end
            r.status = ST_REMOVED;
         end
      end
      r.fill_count = shadow_len[FILL_W-1:0];
      return r;
   endfunction

   // value source: wide random, a narrow band full of ties, or extremes
   function automatic logic signed [DATA_W-1:0] pick_value(input int vmode);
      logic signed [DATA_W-1:0] v;
      case (vmode)
         1: v = $signed($urandom_range(0, 6)) - 3;
         2: begin
            case ($urandom_range(0, 4))
               0:       v = VAL_MAX;
               1:       v = VAL_MIN;
               2:       v = '0;
               3:       v = '1;
               default: v = $urandom;
            endcase
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= SHOW_LIMIT) $display("mismatch at %0t: %s", $time, what);
   endtask

   task automatic add_row(input action_type act, input logic signed [DATA_W-1:0] val,
                          input bit typed, input logic signed [DATA_W-1:0] out_v,
                          input status_type st, input int fill);
      dir_row_type row;
      row.act              = act;
      row.val              = val;
      row.typed            = typed;
      row.want.out_value   = out_v;
      row.want.status      = st;
      row.want.fill_count  = fill[FILL_W-1:0];
      dir_rows.push_back(row);
   endtask

   // present one request, hold it until taken, then record what it should return
   task automatic send_request(input action_type act, input logic signed [DATA_W-1:0] val,
                               input bit typed, input reply_type typed_want);
      reply_type want;
      req_bus.valid  <= 1'b1;
      req_bus.action <= act;
      req_bus.value  <= val;
      do @(posedge clock); while (!req_bus.ready);
      want = heap_step(act, val);
      replies_due.push_back(typed ? typed_want : want);
      items_sent++;
      // bursts of back-to-back requests with random gaps in between
      burst_left--;
      if (burst_left <= 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90)
                                                  : $urandom_range(1, 12);
      end
   endtask

   // hold off until the queue has answered every request
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // response checker
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (replies_due.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = replies_due.pop_front();
            if (rsp_bus.out_value !== want.out_value)
               report_mismatch($sformatf("out_value %0d, expected %0d",
                                         rsp_bus.out_value, want.out_value));
            if (rsp_bus.status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_bus.status, want.status));
            if (rsp_bus.fill_count !== want.fill_count)
               report_mismatch($sformatf("fill_count %0d, expected %0d",
                                         rsp_bus.fill_count, want.fill_count));
         end
      end
   end

   // response side back-pressure, switching between stall patterns
   initial begin
      int mode, span, tick;
      rsp_bus.ready = 1'b0;
      tick = 0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 160);
         repeat (span) begin
            @(posedge clock);
            tick++;
            case (mode)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= ($urandom_range(0, 1) == 1);
               2:       rsp_bus.ready <= (tick % 3 == 0);
               default: rsp_bus.ready <= ($urandom_range(0, 15) == 0);
            endcase
         end
      end
   end

   // stimulus
   initial begin
      int                       phase_no, mode, vmode, span, insert_pct;
      dir_row_type              row;
      reply_type                no_want;
      action_type               act;
      logic signed [DATA_W-1:0] val;

      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.action = ACT_INSERT;
      req_bus.value  = '0;
      shadow_len     = 0;
      error_count    = 0;
      items_sent     = 0;
      burst_left     = 1;
      no_want        = '0;

      // removal from empty, extremes in and out, the value ignored on removal
      add_row(ACT_REMOVE, '0,             1'b1, '0,      ST_EMPTY,    0);
      add_row(ACT_REMOVE, 32'hFFFF_FFFF,  1'b1, '0,      ST_EMPTY,    0);
      add_row(ACT_INSERT, VAL_MAX,        1'b1, '0,      ST_INSERTED, 1);
      add_row(ACT_INSERT, VAL_MIN,        1'b1, '0,      ST_INSERTED, 2);
      add_row(ACT_INSERT, '0,             1'b1, '0,      ST_INSERTED, 3);
      add_row(ACT_INSERT, -1,             1'b1, '0,      ST_INSERTED, 4);
      add_row(ACT_INSERT, VAL_MAX,        1'b1, '0,      ST_INSERTED, 5);
      add_row(ACT_REMOVE, 32'h5555_5555,  1'b1, VAL_MAX, ST_REMOVED,  4);
      add_row(ACT_REMOVE, 32'hAAAA_AAAA,  1'b1, VAL_MAX, ST_REMOVED,  3);
      add_row(ACT_REMOVE, '0,             1'b1, '0,      ST_REMOVED,  2);
      add_row(ACT_REMOVE, '0,             1'b1, -1,      ST_REMOVED,  1);
      add_row(ACT_REMOVE, '0,             1'b1, VAL_MIN, ST_REMOVED,  0);
      add_row(ACT_REMOVE, '0,             1'b1, '0,      ST_EMPTY,    0);
      // equal priorities and alternating bit patterns
      add_row(ACT_INSERT, 5,              1'b0, '0,      ST_INSERTED, 0);
      add_row(ACT_INSERT, 5,              1'b0, '0,      ST_INSERTED, 0);
      add_row(ACT_INSERT, 7,              1'b0, '0,      ST_INSERTED, 0);
      add_row(ACT_INSERT, 5,              1'b0, '0,      ST_INSERTED, 0);
      add_row(ACT_INSERT, 3,              1'b0, '0,      ST_INSERTED, 0);
      add_row(ACT_INSERT, 32'h5555_5555,  1'b0, '0,      ST_INSERTED, 0);
      add_row(ACT_INSERT, 32'hAAAA_AAAA,  1'b0, '0,      ST_INSERTED, 0);
      add_row(ACT_REMOVE, 32'h5555_5555,  1'b0, '0,      ST_REMOVED,  0);
      add_row(ACT_REMOVE, 32'hAAAA_AAAA,  1'b0, '0,      ST_REMOVED,  0);
      add_row(ACT_REMOVE, '1,             1'b0, '0,      ST_REMOVED,  0);
      add_row(ACT_REMOVE, '0,             1'b0, '0,      ST_REMOVED,  0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         send_request(row.act, row.val, row.typed, row.want);
      end
      wait_drained();

      // random phases: fill to full, drain to empty, or mixed traffic
      phase_no = 0;
      while (items_sent < dir_rows.size() + RANDOM_ITEMS) begin
         mode  = (phase_no < 2) ? phase_no : $urandom_range(0, 4);
         vmode = $urandom_range(0, 2);
         case (mode)
            0: begin
               while (shadow_len < CAPACITY)
                  send_request(ACT_INSERT, pick_value(vmode), 1'b0, no_want);
               repeat ($urandom_range(1, 3))
                  send_request(ACT_INSERT, pick_value(vmode), 1'b0, no_want);
               wait_drained();
            end
            1: begin
               while (shadow_len > 0)
                  send_request(ACT_REMOVE, $urandom, 1'b0, no_want);
               repeat ($urandom_range(1, 3))
                  send_request(ACT_REMOVE, $urandom, 1'b0, no_want);
               wait_drained();
            end
            default: begin
               insert_pct = (mode == 2) ? 70 : (mode == 3) ? 30 : 50;
               span = $urandom_range(30, 150);
               repeat (span) begin
                  act = ($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_REMOVE;
                  val = (act == ACT_INSERT) ? pick_value(vmode) : $urandom;
                  send_request(act, val, 1'b0, no_want);
               end
            end
         endcase
         phase_no++;
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire
